@@ hw/rtl/bpch_pkg.sv @@
package bpch_pkg;

    // Fixed field widths of the channels
    localparam int CHAN_W      = 4;
    localparam int SAMPLE_W    = 16;
    localparam int OUT_COUNT_W = 12;
    localparam int SLOT_W      = 4;
    localparam int HLEN_W      = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_CHANNEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_CHANNEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH = 3'd4;

    localparam logic [HLEN_W-1:0] HISTORY_LENGTH_RESET = 5'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic step;     // accepted sample: run detectors, push on block end
        logic load;     // read the oldest emitted slot
        logic advance;  // read the next slot
    } bpch_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_slot;
    } bpch_sts_t;

endpackage

@@ hw/rtl/bpch_if.sv @@
interface bpch_sample_if;
    import bpch_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       block_end;

    modport source (output valid, chan, sample_value, block_end, input ready);
    modport sink   (input valid, chan, sample_value, block_end, output ready);
endinterface

interface bpch_result_if;
    import bpch_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [OUT_COUNT_W-1:0] pos_count;
    logic [OUT_COUNT_W-1:0] neg_count;
    logic [SLOT_W-1:0]      slot_index;
    logic                   last;

    modport source (output valid, pos_count, neg_count, slot_index, last, input ready);
    modport sink   (input valid, pos_count, neg_count, slot_index, last, output ready);
endinterface

interface bpch_cfg_if;
    import bpch_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bpch_detector.sv @@
module bpch_detector #(
    parameter int COUNT_WIDTH = 12,
    parameter bit NEGATIVE    = 1'b0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic                                 flush,
    input  logic signed [bpch_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [bpch_pkg::SAMPLE_W-1:0] threshold,
    output logic [COUNT_WIDTH-1:0]               count_upd
);
    import bpch_pkg::*;

    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                       have_reg, have_next;
    logic                       armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0]     cnt_reg, cnt_next;

    logic signed [SAMPLE_W:0]   prev_ext, samp_ext;
    logic [SAMPLE_W:0]          cm, nm;
    logic                       below;
    logic                       past;
    logic                       armed_kept;

    // Exact magnitudes, -32768 maps to 32768
    assign prev_ext = {prev_reg[SAMPLE_W-1], prev_reg};
    assign samp_ext = {sample[SAMPLE_W-1], sample};
    assign cm = prev_reg[SAMPLE_W-1] ? $unsigned(-prev_ext) : $unsigned(prev_ext);
    assign nm = sample[SAMPLE_W-1] ? $unsigned(-samp_ext) : $unsigned(samp_ext);

    // Threshold tests
    assign below = $signed({1'b0, cm}) < $signed({{2{threshold[SAMPLE_W-1]}}, threshold});
    assign past  = NEGATIVE ? (prev_reg < threshold) : (prev_reg > threshold);
    assign armed_kept = below ? 1'b0 : armed_reg;

    // Arm on rise, count on fall past the threshold
    always_comb
    begin
        prev_next  = prev_reg;
        have_next  = have_reg;
        armed_next = armed_reg;
        count_upd  = cnt_reg;
        if (step)
        begin
            if (have_reg)
            begin
                armed_next = armed_kept;
                if (cm < nm)
                begin
                    armed_next = 1'b1;
                end
                else if (cm > nm && armed_kept && past)
                begin
                    if (cnt_reg != {COUNT_WIDTH{1'b1}})
                    begin
                        count_upd = cnt_reg + 1'b1;
                    end
                    armed_next = 1'b0;
                end
            end
            prev_next = sample;
            have_next = 1'b1;
        end
    end

    assign cnt_next = flush ? '0 : count_upd;

    // Hold detector state, clear at block end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            have_reg  <= 1'b0;
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (flush)
        begin
            prev_reg  <= '0;
            have_reg  <= 1'b0;
            armed_reg <= 1'b0;
            cnt_reg   <= cnt_next;
        end
        else
        begin
            prev_reg  <= prev_next;
            have_reg  <= have_next;
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/bpch_datapath.sv @@
module bpch_datapath #(
    parameter int HISTORY_DEPTH = 16,
    parameter int NUM_CHANNELS  = 16,
    parameter int COUNT_WIDTH   = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bpch_pkg::bpch_cmd_t                     cmd,
    output bpch_pkg::bpch_sts_t                     sts,
    input  logic [bpch_pkg::CHAN_W-1:0]             chan,
    input  logic signed [bpch_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic                                    block_end,
    input  logic                                    cfg_write,
    input  logic [bpch_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [bpch_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic [bpch_pkg::OUT_COUNT_W-1:0]        pos_count,
    output logic [bpch_pkg::OUT_COUNT_W-1:0]        neg_count,
    output logic [bpch_pkg::SLOT_W-1:0]             slot_index,
    output logic                                    last
);
    import bpch_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int LW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = (LW > HLEN_W) ? LW : HLEN_W;
    localparam int MW = 2 * COUNT_WIDTH;

    // Configuration registers
    logic signed [SAMPLE_W-1:0] pos_thr_reg, neg_thr_reg;
    logic [CHAN_W-1:0]          pos_chan_reg, neg_chan_reg;
    logic [HLEN_W-1:0]          hlen_reg;

    // History ring and read side
    logic [MW-1:0]              mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]   valid_reg;
    logic [AW-1:0]              wr_ptr_reg;
    logic [AW-1:0]              rd_ptr_reg, rd_addr;
    logic [MW-1:0]              rd_data_reg;
    logic                       rd_valid_reg;
    logic [LW-1:0]              slot_reg;
    logic [LW-1:0]              len_reg;

    logic                       chan_ok;
    logic                       pos_hit, neg_hit;
    logic                       push;
    logic [COUNT_WIDTH-1:0]     pos_upd, neg_upd;
    logic [CW-1:0]              hlen_ext;
    logic [LW-1:0]              len_eff;
    logic [LW-1:0]              wr_ext;
    logic [LW-1:0]              start_diff;
    logic [AW-1:0]              start_addr;
    logic [AW-1:0]              rd_ptr_inc;
    logic [COUNT_WIDTH-1:0]     pos_raw, neg_raw;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] pos_wide, neg_wide;
    logic [LW+SLOT_W-1:0]       slot_wide;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_thr_reg  <= '0;
            neg_thr_reg  <= '0;
            pos_chan_reg <= '0;
            neg_chan_reg <= '0;
            hlen_reg     <= HISTORY_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_POS_THRESHOLD:  pos_thr_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_NEG_THRESHOLD:  neg_thr_reg  <= $signed(cfg_data[SAMPLE_W-1:0]);
                CFG_POS_CHANNEL:    pos_chan_reg <= cfg_data[CHAN_W-1:0];
                CFG_NEG_CHANNEL:    neg_chan_reg <= cfg_data[CHAN_W-1:0];
                CFG_HISTORY_LENGTH: hlen_reg     <= cfg_data[HLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Route the sample to the detectors
    assign chan_ok = {5'd0, chan} < 9'(NUM_CHANNELS);
    assign pos_hit = cmd.step && chan_ok && (chan == pos_chan_reg);
    assign neg_hit = cmd.step && chan_ok && (chan == neg_chan_reg);
    assign push    = cmd.step && block_end;

    bpch_detector #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .NEGATIVE    (1'b0)
    ) u_pos_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (pos_hit),
        .flush     (push),
        .sample    (sample_value),
        .threshold (pos_thr_reg),
        .count_upd (pos_upd)
    );

    bpch_detector #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .NEGATIVE    (1'b1)
    ) u_neg_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (neg_hit),
        .flush     (push),
        .sample    (sample_value),
        .threshold (neg_thr_reg),
        .count_upd (neg_upd)
    );

    // Clamp the emitted length to 1..HISTORY_DEPTH
    assign hlen_ext = CW'(hlen_reg);
    always_comb
    begin
        if (hlen_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (hlen_ext > CW'(HISTORY_DEPTH))
        begin
            len_eff = LW'(HISTORY_DEPTH);
        end
        else
        begin
            len_eff = hlen_ext[LW-1:0];
        end
    end

    // Oldest emitted slot sits len entries behind the write pointer
    assign wr_ext = LW'(wr_ptr_reg);
    assign start_diff = (wr_ext >= len_eff) ? (wr_ext - len_eff)
                                            : (wr_ext + LW'(HISTORY_DEPTH) - len_eff);
    assign start_addr = start_diff[AW-1:0];
    assign rd_ptr_inc = (rd_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign rd_addr    = cmd.load ? start_addr : rd_ptr_inc;

    // Push counts into the ring, advance the write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            valid_reg  <= '0;
        end
        else if (push)
        begin
            wr_ptr_reg <= (wr_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            valid_reg[wr_ptr_reg] <= 1'b1;
        end
    end

    // History memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {pos_upd, neg_upd};
        end
        if (cmd.load || cmd.advance)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track read position and slot number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= '0;
            rd_valid_reg <= 1'b0;
            slot_reg     <= '0;
            len_reg      <= LW'(1);
        end
        else if (cmd.load)
        begin
            rd_ptr_reg   <= start_addr;
            rd_valid_reg <= valid_reg[start_addr];
            slot_reg     <= '0;
            len_reg      <= len_eff;
        end
        else if (cmd.advance)
        begin
            rd_ptr_reg   <= rd_ptr_inc;
            rd_valid_reg <= valid_reg[rd_ptr_inc];
            slot_reg     <= slot_reg + 1'b1;
        end
    end

    // Drive result fields; never-written slots read as zero
    assign pos_raw    = rd_valid_reg ? rd_data_reg[MW-1:COUNT_WIDTH] : '0;
    assign neg_raw    = rd_valid_reg ? rd_data_reg[COUNT_WIDTH-1:0] : '0;
    assign pos_wide   = {{OUT_COUNT_W{1'b0}}, pos_raw};
    assign neg_wide   = {{OUT_COUNT_W{1'b0}}, neg_raw};
    assign slot_wide  = {{SLOT_W{1'b0}}, slot_reg};
    assign pos_count  = pos_wide[OUT_COUNT_W-1:0];
    assign neg_count  = neg_wide[OUT_COUNT_W-1:0];
    assign slot_index = slot_wide[SLOT_W-1:0];
    assign last       = (slot_reg + 1'b1) == len_reg;

    assign sts.last_slot = last;

endmodule

@@ hw/rtl/bpch_ctrl.sv @@
module bpch_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_block_end,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bpch_pkg::bpch_sts_t sts,
    output bpch_pkg::bpch_cmd_t cmd
);
    import bpch_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   in_acc, out_acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SHOW);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    // Sequence sample steps and history readout
    always_comb
    begin
        state_next  = state_reg;
        cmd.step    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.step = in_acc;
                if (in_acc && in_block_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_acc)
                begin
                    if (sts.last_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/block_peak_counter_history_unit.sv @@
// Block peak counter with history.
//
// smp (sink): one signed sample per request, tagged with its channel and a
// block_end mark. Two detectors count positive and negative peaks on their
// configured channels and thresholds.
// res (source): at each block end the history of (pos_count, neg_count) is
// emitted oldest first, one slot per request, slot_index counting from 0 and
// last set on the newest slot.
// cfg (sink): register writes by index, always ready; write only while idle.
//
// Samples without block_end stream at one per cycle while no readout is in
// progress. A block-end sample is pushed into the history, then the load
// state registers the first history memory read, then results follow at one
// per cycle while res is ready. The single-port read of the history memory
// sets the result rate. A stall on res holds the current result; smp stays
// not ready until the last slot is taken.
// Reset clears detectors, counts and history (all slots read as zero) and
// loads the register defaults; the block comes out of reset ready for samples.
module block_peak_counter_history_unit #(
    parameter int HISTORY_DEPTH = 16,
    parameter int NUM_CHANNELS  = 16,
    parameter int COUNT_WIDTH   = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    bpch_sample_if.sink   smp,
    bpch_result_if.source res,
    bpch_cfg_if.sink      cfg
);
    import bpch_pkg::*;

    bpch_cmd_t cmd;
    bpch_sts_t sts;

    assign cfg.ready = 1'b1;

    bpch_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (smp.valid),
        .in_block_end (smp.block_end),
        .in_ready     (smp.ready),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    bpch_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .NUM_CHANNELS  (NUM_CHANNELS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .chan         (smp.chan),
        .sample_value (smp.sample_value),
        .block_end    (smp.block_end),
        .cfg_write    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .pos_count    (res.pos_count),
        .neg_count    (res.neg_count),
        .slot_index   (res.slot_index),
        .last         (res.last)
    );

    // Never take a sample while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        !(smp.ready && res.valid))
        else $error("sample accepted during history readout");

    // A block end leads to the memory read cycle, not a new request
    assert property (@(posedge clk) disable iff (!rst_n)
        (smp.valid && smp.ready && smp.block_end) |=> (!smp.ready && !res.valid))
        else $error("block end did not start readout");

    // Readout starts at the oldest slot
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> (res.slot_index == '0))
        else $error("readout did not start at slot zero");

    // Taking the last slot returns the block to sampling
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last) |=> (smp.ready && !res.valid))
        else $error("block did not return to idle after last slot");

endmodule
